// File: design/gspc_pkg.sv
// Package for the gradient sprite pixel compositor.
// Holds command codes, the sprite slot entry type and result helpers.
// No dependencies.
package gspc_pkg;

    typedef enum logic [2:0] {
        CMD_PIXEL  = 3'd0,
        CMD_FRAME  = 3'd1,
        CMD_COLOR  = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_CREATE = 3'd4,
        CMD_WRITE  = 3'd5
    } t_cmd;

    localparam logic [7:0]  START_RESET = 8'(8'hFF >> 1);
    localparam logic [8:0]  FOLD_TOP    = 9'd496;
    localparam logic [8:0]  FOLD_AT     = 9'd248;
    localparam logic [7:0]  TURN_LEVEL  = 8'd240;
    localparam logic [15:0] WHITE       = 16'hFFFF;
    localparam logic [15:0] BLANK       = 16'h0000;

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [11:0] base;
    } t_sprite;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

// File: design/gradient_sprite_pixel_compositor_unit.sv
// Top level of the gradient sprite pixel compositor.
// Depends on gspc_pkg. Sprite words live in one synchronous memory.
//
// channel  | dir | data (low bit up)
// s_axis   | in  | tuser: cmd (3 bits)
//          |     | tdata: line, column, sprite_x, sprite_y, sprite_w,
//          |     |        sprite_h, sprite_base, mem_addr, mem_data (96 bits)
// m_axis   | out | tdata: pixel, slot, no_free_slot (24 bits)
//
// A pixel beat on screen off the border columns visits each slot in turn:
// the slot is checked in S_SCAN and its sprite-memory read returns in the next
// state, S_READ (one read port); other beats go to S_DONE. One beat is worked
// on at a time; input waits until the result register is empty or being taken.
// Reset: synchronous, clears slot valid bits; resets gradient and color state.
module gradient_sprite_pixel_compositor_unit #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int SPRITE_SLOTS  = 8,
    parameter int SPRITE_WORDS  = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [2:0]   s_axis_tuser,  // cmd
    input  logic [95:0]  s_axis_tdata,  // line,column,sprite_x,sprite_y,sprite_w,
                                        // sprite_h,sprite_base,mem_addr,mem_data
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata   // pixel,slot,no_free_slot,pad
);
    import gspc_pkg::*;

    localparam int SW = $clog2(SPRITE_SLOTS) > 0 ? $clog2(SPRITE_SLOTS) : 1;
    localparam int AW = $clog2(SPRITE_WORDS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_DONE} t_state;

    logic [15:0] r_mem [SPRITE_WORDS];
    logic [15:0] r_rdata;
    logic        mem_re;
    logic [AW-1:0] mem_raddr;

    t_sprite     r_tab [SPRITE_SLOTS];
    logic [SPRITE_SLOTS-1:0] r_vis;

    t_state      r_state;
    logic [SW-1:0] r_idx;
    logic [9:0]  r_line, r_col;
    logic [15:0] r_px;
    logic        r_hit;
    logic [7:0]  r_start;
    logic        r_rising;
    logic [1:0]  r_color;
    logic        r_ovalid;
    logic [15:0] r_opix;
    logic [2:0]  r_oslot;
    logic        r_ofull;

    t_cmd        cmd;
    logic [9:0]  in_line, in_col;
    logic        acc;
    t_sprite     in_spr;

    assign cmd     = t_cmd'(s_axis_tuser);
    assign in_line = s_axis_tdata[9:0];
    assign in_col  = s_axis_tdata[19:10];
    assign in_spr  = '{x: s_axis_tdata[29:20], y: s_axis_tdata[39:30],
                       w: s_axis_tdata[47:40], h: s_axis_tdata[55:48],
                       base: s_axis_tdata[67:56]};
    assign acc     = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_ofull, r_oslot, r_opix};

    // background
    logic [15:0] bg;
    logic [10:0] s_sum;
    logic [7:0]  bri;
    logic        on_screen;
    logic        inner_col;
    always_comb begin
        s_sum = 11'(r_start) + 11'(in_line);
        if (s_sum < 11'(FOLD_AT))
            bri = s_sum[7:0];
        else if (s_sum <= 11'(FOLD_TOP))
            bri = 8'(11'(FOLD_TOP) - s_sum);
        else
            bri = 8'd0;
        unique case (r_color)
            COLOR_BLUE:  bg = swap16({11'd0, bri[7:3]});
            COLOR_GREEN: bg = swap16({5'd0, bri[7:2], 5'd0});
            default:     bg = swap16({bri[7:3], 11'd0});
        endcase
        if (in_line == 10'd0 || 32'(in_line) == SCREEN_HEIGHT - 1 ||
            in_col == 10'd0 || 32'(in_col) == SCREEN_WIDTH - 1)
            bg = WHITE;
        on_screen = (32'(in_line) < SCREEN_HEIGHT) && (32'(in_col) < SCREEN_WIDTH);
        inner_col = (in_col != 10'd0) && (32'(in_col) != SCREEN_WIDTH - 1);
    end

    // slot hit check
    t_sprite     e;
    logic        hit;
    logic [10:0] dy, dx;
    logic [19:0] off;
    always_comb begin
        e   = r_tab[r_idx];
        dy  = 11'(r_line) - 11'(e.y);
        dx  = 11'(r_col) - 11'(e.x);
        hit = r_vis[r_idx] && (r_line >= e.y) && (11'(r_line) < 11'(e.y) + 11'(e.h))
              && (r_col >= e.x) && (11'(r_col) < 11'(e.x) + 11'(e.w));
        off = 20'(dy[7:0] * e.w);
        mem_raddr = AW'(32'(e.base) + 32'(off) + 32'(dx));
        mem_re = (r_state == S_SCAN) && hit;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) r_rdata <= r_mem[mem_raddr];
        if (acc && cmd == CMD_WRITE)
            r_mem[AW'(s_axis_tdata[79:68])] <= s_axis_tdata[95:80];
    end

    logic [SW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SPRITE_SLOTS - 1; i >= 0; i--) begin
            if (!r_vis[i]) begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [7:0] n_start;
    always_comb n_start = r_rising ? r_start + 8'd1 : r_start - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vis    <= '0;
            r_start  <= START_RESET;
            r_rising <= 1'b1;
            r_color  <= COLOR_RED;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || m_axis_tready))
                r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_opix  <= BLANK;
                        r_oslot <= (cmd == CMD_CREATE && free_any) ? 3'(free_idx) : 3'd0;
                        r_ofull <= (cmd == CMD_CREATE) && !free_any;
                        r_line  <= in_line;
                        r_col   <= in_col;
                        r_px    <= (cmd == CMD_PIXEL && on_screen) ? bg : BLANK;
                        r_idx   <= '0;
                        r_state <= (cmd == CMD_PIXEL && on_screen && inner_col)
                                   ? S_SCAN : S_DONE;
                        unique case (cmd)
                            CMD_FRAME: begin
                                r_start <= n_start;
                                if (n_start > TURN_LEVEL) r_rising <= 1'b0;
                                else if (n_start == 8'd0) r_rising <= 1'b1;
                            end
                            CMD_COLOR:
                                r_color <= (r_color == COLOR_BLUE) ? COLOR_RED
                                         : (r_color == COLOR_GREEN) ? COLOR_BLUE
                                         : COLOR_GREEN;
                            CMD_CLEAR: r_vis <= '0;
                            CMD_CREATE: begin
                                if (free_any) begin
                                    r_vis[free_idx] <= 1'b1;
                                    r_tab[free_idx] <= in_spr;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_hit   <= hit;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_hit && r_rdata != BLANK) r_px <= swap16(r_rdata);
                    if (32'(r_idx) == SPRITE_SLOTS - 1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + SW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_opix   <= r_px;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_opix)) else $error("out");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("busy");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ofull && r_ovalid |-> r_oslot == 3'd0) else $error("full");
endmodule

// File: bench/testbench.sv
// Self-checking bench for gradient_sprite_pixel_compositor_unit.
// Drives directed and random command beats; checks listed or predicted results.
// Depends on gspc_pkg and the top level RTL.
module testbench;
    import gspc_pkg::*;

    localparam int SW = 320;
    localparam int SH = 240;
    localparam int SLOTS = 8;
    localparam int WORDS = 4096;
    localparam int N_RANDOM = 1530;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  line;
        logic [9:0]  column;
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [7:0]  sw;
        logic [7:0]  sh;
        logic [11:0] base;
        logic [11:0] addr;
        logic [15:0] data;
    } t_req;

    typedef struct packed {
        logic        full;
        logic [2:0]  slot;
        logic [15:0] pixel;
    } t_res;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [2:0]   s_axis_tuser = '0;   // cmd
    logic [95:0]  s_axis_tdata = '0;   // line,column,sprite_x,sprite_y,sprite_w,
                                       // sprite_h,sprite_base,mem_addr,mem_data
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;        // pixel,slot,no_free_slot

    t_sprite     spr [SLOTS];
    bit          spr_on [SLOTS];
    logic [15:0] smem [WORDS];
    bit          smem_set [WORDS];
    int          level;
    bit          climbing;
    int          hue;

    t_res pending_px[$];
    int   errors = 0;
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;
    t_row rows[$];

    gradient_sprite_pixel_compositor_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit covers(int k, int ln, int col);
        return spr_on[k] && ln >= spr[k].y && ln < int'(spr[k].y) + int'(spr[k].h)
            && col >= spr[k].x && col < int'(spr[k].x) + int'(spr[k].w);
    endfunction

    function automatic int word_addr(int k, int ln, int col);
        return (int'(spr[k].base) + (ln - int'(spr[k].y)) * int'(spr[k].w)
                + (col - int'(spr[k].x))) % WORDS;
    endfunction

    function automatic bit hits_unset(int ln, int col);
        if (ln >= SH || col < 1 || col >= SW - 1) return 1'b0;
        for (int k = 0; k < SLOTS; k++)
            if (covers(k, ln, col) && !smem_set[word_addr(k, ln, col)]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [15:0] shade_at(int ln, int col);
        int s;
        int b;
        logic [15:0] v;
        if (ln == 0 || ln == SH - 1 || col == 0 || col == SW - 1) return WHITE;
        s = level + ln;
        b = (s < 248) ? s : (s <= 496) ? 496 - s : 0;
        if (hue == 2) v = 16'(b >> 3);
        else if (hue == 1) v = 16'((b & 'hFC) << 3);
        else v = 16'((b & 'hF8) << 8);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic t_res compose(t_req r);
        t_res o;
        int ln;
        int col;
        logic [15:0] w;
        o = '0;
        ln = r.line;
        col = r.column;
        case (r.cmd)
            CMD_PIXEL: begin
                if (ln < SH && col < SW) begin
                    o.pixel = shade_at(ln, col);
                    if (col >= 1 && col < SW - 1)
                        for (int k = 0; k < SLOTS; k++)
                            if (covers(k, ln, col)) begin
                                w = smem[word_addr(k, ln, col)];
                                if (w != 0) o.pixel = {w[7:0], w[15:8]};
                            end
                end
            end
            CMD_FRAME: begin
                level = (climbing ? level + 1 : level - 1) & 'hFF;
                if (level > 240) climbing = 1'b0;
                else if (level == 0) climbing = 1'b1;
            end
            CMD_COLOR: hue = (hue + 1) % 3;
            CMD_CLEAR: for (int k = 0; k < SLOTS; k++) spr_on[k] = 1'b0;
            CMD_CREATE: begin
                o.full = 1'b1;
                for (int k = 0; k < SLOTS; k++)
                    if (!spr_on[k] && o.full) begin
                        spr[k] = '{x: r.sx, y: r.sy, w: r.sw, h: r.sh, base: r.base};
                        spr_on[k] = 1'b1;
                        o.slot = 3'(k);
                        o.full = 1'b0;
                    end
            end
            CMD_WRITE: begin
                smem[r.addr] = r.data;
                smem_set[r.addr] = 1'b1;
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic t_req make_req();
        t_req r;
        int p;
        int k;
        r = '0;
        r.line = 10'($urandom);
        r.column = 10'($urandom);
        r.sx = 10'($urandom);
        r.sy = 10'($urandom);
        r.sw = 8'($urandom);
        r.sh = 8'($urandom);
        r.base = 12'($urandom);
        r.addr = 12'($urandom);
        r.data = 16'($urandom);
        p = $urandom_range(0, 99);
        k = $urandom_range(0, SLOTS - 1);
        if (p < 50) begin
            r.cmd = CMD_PIXEL;
            if (spr_on[k] && spr[k].w != 0 && spr[k].h != 0 && $urandom_range(0, 1)) begin
                r.line = 10'(spr[k].y + $urandom_range(0, spr[k].h - 1));
                r.column = 10'(spr[k].x + $urandom_range(0, spr[k].w - 1));
            end else if ($urandom_range(0, 9) != 0) begin
                r.line = 10'($urandom_range(0, SH - 1));
                r.column = 10'($urandom_range(0, SW - 1));
            end
            if (hits_unset(r.line, r.column)) r.column = '0;
        end else if (p < 72) begin
            r.cmd = CMD_WRITE;
            if (spr_on[k] && $urandom_range(0, 2) != 0)
                r.addr = 12'(int'(spr[k].base)
                             + $urandom_range(0, int'(spr[k].w) * int'(spr[k].h)));
            if ($urandom_range(0, 6) == 0) r.data = '0;
        end else if (p < 81) begin
            r.cmd = CMD_CREATE;
            if ($urandom_range(0, 19) != 0) begin
                r.sx = 10'($urandom_range(0, SW));
                r.sy = 10'($urandom_range(0, SH));
                r.sw = 8'($urandom_range(0, 12));
                r.sh = 8'($urandom_range(0, 12));
            end
        end else if (p < 93) r.cmd = CMD_FRAME;
        else if (p < 96) r.cmd = CMD_COLOR;
        else if (p < 98) r.cmd = CMD_CLEAR;
        else r.cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
        return r;
    endfunction

    function automatic t_req req_of(logic [2:0] c, int ln, int col, int sx, int sy,
                                    int sw, int sh, int base, int addr, int data);
        return '{cmd: c, line: 10'(ln), column: 10'(col), sx: 10'(sx), sy: 10'(sy),
                 sw: 8'(sw), sh: 8'(sh), base: 12'(base), addr: 12'(addr),
                 data: 16'(data)};
    endfunction

    task automatic add_row(t_req r, bit typed, logic [15:0] px, logic [2:0] sl, bit fl);
        t_row w;
        w.req = r;
        w.typed = typed;
        w.res = '{full: fl, slot: sl, pixel: px};
        rows.push_back(w);
    endtask

    task automatic send(t_req r, bit typed, t_res want);
        t_res got;
        while (!quiet && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.cmd;
        s_axis_tdata <= {r.data, r.addr, r.base, r.sh, r.sw, r.sy, r.sx, r.column, r.line};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = compose(r);
        pending_px.push_back(typed ? want : got);
    endtask

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res act_r;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            act_r = m_axis_tdata[19:0];
            if (pending_px.size() == 0) begin
                errors++;
                $display("unexpected result %h", act_r);
            end else begin
                exp_r = pending_px.pop_front();
                if (act_r !== exp_r || m_axis_tdata[23:20] !== 4'b0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pixel %h/%h slot %0d/%0d full %0d/%0d",
                                 exp_r.pixel, act_r.pixel, exp_r.slot, act_r.slot,
                                 exp_r.full, act_r.full);
                end
            end
        end
    end

    initial begin
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 36);
        end
    end

    initial begin
        t_res none;
        none = '0;
        for (int k = 0; k < SLOTS; k++) spr_on[k] = 1'b0;
        for (int a = 0; a < WORDS; a++) begin
            smem[a] = '0;
            smem_set[a] = 1'b0;
        end
        level = START_RESET;
        climbing = 1'b1;
        hue = COLOR_RED;

        add_row(req_of(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, WHITE, 0, 0);
        add_row(req_of(CMD_PIXEL, 1023, 1023, 1023, 1023, 255, 255, 4095, 4095, 65535),
                1, BLANK, 0, 0);
        add_row(req_of(CMD_PIXEL, 240, 5, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_PIXEL, 100, 320, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_PIXEL, 1, 1, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(req_of(CMD_SPARE_LO, 5, 5, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_SPARE_HI, 1023, 1023, 1023, 1023, 255, 255, 4095, 4095, 65535),
                1, BLANK, 0, 0);
        add_row(req_of(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 4095, 'h1234), 1, BLANK, 0, 0);
        add_row(req_of(CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_CREATE, 0, 0, 1, 0, 2, 1, 4095, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_PIXEL, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, 16'h3412, 0, 0);
        add_row(req_of(CMD_PIXEL, 0, 2, 0, 0, 0, 0, 0, 0, 0), 1, WHITE, 0, 0);
        for (int k = 1; k < SLOTS; k++)
            add_row(req_of(CMD_CREATE, 0, 0, 1023, 1023, 0, 255, 4095, 0, 0),
                    1, BLANK, 3'(k), 0);
        add_row(req_of(CMD_CREATE, 0, 0, 1023, 1023, 255, 255, 4095, 0, 0), 1, BLANK, 0, 1);
        add_row(req_of(CMD_PIXEL, 50, 1, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(req_of(CMD_FRAME, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_COLOR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_PIXEL, 238, 318, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(req_of(CMD_COLOR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);
        add_row(req_of(CMD_PIXEL, 120, 160, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(req_of(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, BLANK, 0, 0);

        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) send(rows[n].req, rows[n].typed, rows[n].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_req = 1'b1;
            if (n == 700) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_px.size() != 0) @(posedge i_clk);
            end
            quiet = (n >= 1000 && n < 1200);
            send(make_req(), 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending_px.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: gradient_sprite_pixel_compositor_unit.f
design/gspc_pkg.sv
design/gradient_sprite_pixel_compositor_unit.sv
bench/testbench.sv
